// ===== sv/tcdi_pkg.sv =====
// shared constants and types for the triangle coverage and depth interpolation block
// no dependencies
package tcdi_pkg;

    // fixed field widths of the stream payload
    localparam int PIX_W   = 12;
    localparam int CRD_W   = 16;
    localparam int Z_W     = 32;
    localparam int WGT_W   = 32;
    localparam int QBITS   = 32;
    localparam int IN_W    = 216;
    localparam int OUT_W   = 128;
    localparam int USER_W  = 2;

    // parameter defaults
    localparam int DEF_SCREEN_BITS      = 12;
    localparam int DEF_SUBPIXEL_BITS    = 4;
    localparam int DEF_WEIGHT_FRAC_BITS = 16;
    localparam int DEF_NUM_W            = 38;

    // tuser bit positions
    localparam int USER_INSIDE = 0;
    localparam int USER_DEGEN  = 1;

    // sideband that rides along with one pixel through the divider cells
    typedef struct packed {
        logic [2:0][Z_W-1:0] z;
        logic [2:0]          neg;
        logic [2:0]          ov;
        logic                degen;
        logic                covered;
    } t_side;

endpackage

// ===== sv/tcdi_edge.sv =====
// edge function setup: differences, products, numerators, magnitudes and divider seed
// depends on tcdi_pkg
module tcdi_edge
    import tcdi_pkg::*;
#(
    parameter int SCREEN_BITS = DEF_SCREEN_BITS,
    parameter int SUBPIXEL_BITS = DEF_SUBPIXEL_BITS,
    parameter int FRAC_W = DEF_WEIGHT_FRAC_BITS,
    parameter int NUM_W = DEF_NUM_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [IN_W-1:0]           i_data,
    output logic                      o_valid,
    output logic [NUM_W-1:0]          o_den,
    output logic [2:0][NUM_W-1:0]     o_rem,
    output logic [2:0][QBITS-1:0]     o_low,
    output t_side                     o_side
);
    localparam int PXI_W = (SCREEN_BITS < PIX_W) ? SCREEN_BITS : PIX_W;
    localparam int PX_W  = PXI_W + SUBPIXEL_BITS;
    localparam int DP_W  = ((PX_W + 1 > CRD_W) ? PX_W + 1 : CRD_W) + 1;
    localparam int VD_W  = CRD_W + 1;
    localparam int N_W   = NUM_W + FRAC_W;

    // input field unpacking
    logic [PIX_W-1:0]        s_pix_x, s_pix_y;
    logic signed [CRD_W-1:0] s_x0, s_y0, s_x1, s_y1, s_x2, s_y2;
    logic [PX_W-1:0]         s_px, s_py;

    assign s_pix_x = i_data[11:0];
    assign s_pix_y = i_data[23:12];
    assign s_x0 = i_data[39:24];
    assign s_y0 = i_data[55:40];
    assign s_x1 = i_data[103:88];
    assign s_y1 = i_data[119:104];
    assign s_x2 = i_data[167:152];
    assign s_y2 = i_data[183:168];
    assign s_px = PX_W'(s_pix_x[PXI_W-1:0]) << SUBPIXEL_BITS;
    assign s_py = PX_W'(s_pix_y[PXI_W-1:0]) << SUBPIXEL_BITS;

    // stage 1 differences
    logic                    r_v1;
    logic signed [VD_W-1:0]  r_e1, r_e2, r_e3, r_e4, r_e5;
    logic signed [DP_W-1:0]  r_dpx, r_dpy;
    t_side                   r_s1;
    logic signed [PX_W:0]    s_spx, s_spy;

    assign s_spx = signed'({1'b0, s_px});
    assign s_spy = signed'({1'b0, s_py});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1  <= VD_W'(s_y1) - VD_W'(s_y2);
            r_e2  <= VD_W'(s_x2) - VD_W'(s_x1);
            r_e3  <= VD_W'(s_y2) - VD_W'(s_y0);
            r_e4  <= VD_W'(s_x0) - VD_W'(s_x2);
            r_e5  <= VD_W'(s_y0) - VD_W'(s_y2);
            r_dpx <= DP_W'(s_spx) - DP_W'(s_x2);
            r_dpy <= DP_W'(s_spy) - DP_W'(s_y2);
            r_s1  <= '{z: {i_data[215:184], i_data[151:120], i_data[87:56]},
                       neg: 3'b000, ov: 3'b000, degen: 1'b0, covered: 1'b0};
        end
    end

    // stage 2 products
    logic                        r_v2;
    logic signed [2*VD_W-1:0]    r_pd0, r_pd1;
    logic signed [DP_W+VD_W-1:0] r_pa0, r_pa1, r_pb0, r_pb1;
    t_side                       r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd0 <= r_e1 * r_e4;
            r_pd1 <= r_e2 * r_e5;
            r_pa0 <= r_e1 * r_dpx;
            r_pa1 <= r_e2 * r_dpy;
            r_pb0 <= r_e3 * r_dpx;
            r_pb1 <= r_e4 * r_dpy;
            r_s2  <= r_s1;
        end
    end

    // stage 3 numerators and denominator
    logic                    r_v3;
    logic signed [NUM_W-1:0] r_d, r_a, r_b;
    t_side                   r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d  <= NUM_W'(r_pd0) + NUM_W'(r_pd1);
            r_a  <= NUM_W'(r_pa0) + NUM_W'(r_pa1);
            r_b  <= NUM_W'(r_pb0) + NUM_W'(r_pb1);
            r_s3 <= r_s2;
        end
    end

    // stage 4 third numerator, coverage, signs and magnitudes
    logic signed [2:0][NUM_W-1:0] s_num;
    logic [2:0]                   s_pos;
    logic [2:0]                   s_neg;
    logic [2:0][NUM_W-1:0]        s_mag;
    logic                         s_dneg;

    always_comb begin
        s_num[0] = r_a;
        s_num[1] = r_b;
        s_num[2] = r_d - r_a - r_b;
        s_dneg   = r_d[NUM_W-1];
        for (int k = 0; k < 3; k++) begin
            s_pos[k] = (s_num[k] != '0) && (s_num[k][NUM_W-1] == s_dneg);
            s_neg[k] = (s_num[k] != '0) && (s_num[k][NUM_W-1] != s_dneg);
            s_mag[k] = s_num[k][NUM_W-1] ? NUM_W'(-s_num[k]) : NUM_W'(s_num[k]);
        end
    end

    logic                  r_v4;
    logic [2:0][NUM_W-1:0] r_mag;
    logic [NUM_W-1:0]      r_mden;
    t_side                 r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag         <= s_mag;
            r_mden        <= s_dneg ? NUM_W'(-r_d) : NUM_W'(r_d);
            r_s4.z        <= r_s3.z;
            r_s4.neg      <= s_neg;
            r_s4.ov       <= 3'b000;
            r_s4.degen    <= (r_d == '0);
            r_s4.covered  <= (r_d != '0) && (&s_pos);
        end
    end

    // stage 5 divider seed: scaled dividend split into remainder and low bits
    logic [2:0][N_W-1:0]   s_nd;
    logic [2:0][NUM_W-1:0] s_rem0;
    logic [2:0]            s_ov;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_nd[k]   = N_W'(r_mag[k]) << FRAC_W;
            s_rem0[k] = NUM_W'(s_nd[k][N_W-1:QBITS]);
            s_ov[k]   = (s_rem0[k] >= r_mden);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den <= r_mden;
            for (int k = 0; k < 3; k++) begin
                o_rem[k] <= s_rem0[k];
                o_low[k] <= s_nd[k][QBITS-1:0];
            end
            o_side.z       <= r_s4.z;
            o_side.neg     <= r_s4.neg;
            o_side.ov      <= s_ov;
            o_side.degen   <= r_s4.degen;
            o_side.covered <= r_s4.covered;
        end
    end

endmodule

// ===== sv/tcdi_div_cell.sv =====
// one restoring division step for the three weight lanes, passing its pixel to the next cell
// depends on tcdi_pkg
module tcdi_div_cell
    import tcdi_pkg::*;
#(
    parameter int NUM_W = DEF_NUM_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NUM_W-1:0]      i_den,
    input  logic [2:0][NUM_W-1:0] i_rem,
    input  logic [2:0][QBITS-1:0] i_low,
    input  logic [2:0][QBITS-1:0] i_quo,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_den,
    output logic [2:0][NUM_W-1:0] o_rem,
    output logic [2:0][QBITS-1:0] o_low,
    output logic [2:0][QBITS-1:0] o_quo,
    output t_side                 o_side
);
    logic [2:0][NUM_W:0]   s_rem2;
    logic [2:0][NUM_W-1:0] n_rem;
    logic [2:0]            s_bit;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_rem2[k] = {i_rem[k], i_low[k][QBITS-1]};
            s_bit[k]  = (s_rem2[k] >= {1'b0, i_den});
            n_rem[k]  = s_bit[k] ? NUM_W'(s_rem2[k] - {1'b0, i_den})
                                 : s_rem2[k][NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den  <= i_den;
            o_side <= i_side;
            for (int k = 0; k < 3; k++) begin
                o_rem[k] <= n_rem[k];
                o_low[k] <= i_low[k] << 1;
                o_quo[k] <= {i_quo[k][QBITS-2:0], s_bit[k]};
            end
        end
    end

endmodule

// ===== sv/tcdi_depth.sv =====
// weight saturation, depth products, sum and output register
// depends on tcdi_pkg
module tcdi_depth
    import tcdi_pkg::*;
#(
    parameter int FRAC_W = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][QBITS-1:0] i_quo,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_data,
    output logic [USER_W-1:0]     o_user
);
    localparam int P_W = 2 * WGT_W;
    localparam int S_W = P_W + 2;
    localparam logic signed [WGT_W-1:0] W_MAX = {1'b0, {(WGT_W-1){1'b1}}};
    localparam logic signed [WGT_W-1:0] W_MIN = {1'b1, {(WGT_W-1){1'b0}}};
    localparam logic [QBITS-1:0] Q_LIM = {1'b1, {(QBITS-1){1'b0}}};

    // signed, saturated weights
    logic signed [2:0][WGT_W-1:0] s_w;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_side.degen) begin
                s_w[k] = '0;
            end else if (!i_side.neg[k]) begin
                s_w[k] = (i_side.ov[k] || i_quo[k][QBITS-1]) ? W_MAX : WGT_W'(i_quo[k]);
            end else begin
                s_w[k] = (i_side.ov[k] || (i_quo[k] > Q_LIM)) ? W_MIN
                                                              : WGT_W'(-i_quo[k]);
            end
        end
    end

    logic                         r_v1;
    logic signed [2:0][WGT_W-1:0] r_w;
    logic [2:0][Z_W-1:0]          r_z;
    logic [USER_W-1:0]            r_u1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w  <= s_w;
            r_z  <= i_side.z;
            r_u1 <= {i_side.degen, i_side.covered};
        end
    end

    // weight times vertex depth
    logic                         r_v2;
    logic signed [2:0][P_W-1:0]   r_prod;
    logic signed [2:0][WGT_W-1:0] r_w2;
    logic [USER_W-1:0]            r_u2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= signed'(r_w[k]) * signed'(r_z[k]);
            end
            r_w2 <= r_w;
            r_u2 <= r_u1;
        end
    end

    // exact sum of the three products
    logic                         r_v3;
    logic signed [S_W-1:0]        r_sum;
    logic signed [2:0][WGT_W-1:0] r_w3;
    logic [USER_W-1:0]            r_u3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= S_W'(signed'(r_prod[0])) + S_W'(signed'(r_prod[1]))
                   + S_W'(signed'(r_prod[2]));
            r_w3  <= r_w2;
            r_u3  <= r_u2;
        end
    end

    // floor by the fraction scale, saturate, register the result
    logic signed [S_W-1:0]   s_shr;
    logic signed [WGT_W-1:0] s_dep;

    always_comb begin
        s_shr = r_sum >>> FRAC_W;
        if (s_shr > S_W'(W_MAX)) begin
            s_dep = W_MAX;
        end else if (s_shr < S_W'(W_MIN)) begin
            s_dep = W_MIN;
        end else begin
            s_dep = s_shr[WGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= {s_dep, r_w3[2], r_w3[1], r_w3[0]};
            o_user <= r_u3;
        end
    end

endmodule

// ===== sv/triangle_coverage_depth_interp.sv =====
// Triangle coverage test with barycentric depth interpolation. One pixel corner
// and one triangle enter per transaction, one result leaves per transaction, and a
// new transaction is taken every clock while the output side keeps up. The pipeline has
// five setup stages for the edge functions, a chain of 32 division cells that each
// settle one quotient bit of all three weights, and four stages for weight
// saturation, depth products, sum and output. The whole pipeline holds when
// a finished result waits at the output, so ready follows the output side.
// depends on tcdi_pkg, tcdi_edge, tcdi_div_cell, tcdi_depth
module triangle_coverage_depth_interp
    import tcdi_pkg::*;
#(
    parameter int SCREEN_BITS = DEF_SCREEN_BITS,
    parameter int SUBPIXEL_BITS = DEF_SUBPIXEL_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // pixel_x, pixel_y, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  logic [IN_W-1:0]   i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // weight_a, weight_b, weight_c, depth
    output logic [OUT_W-1:0]  o_m_tdata,
    // inside_res, degenerate
    output logic [USER_W-1:0] o_m_tuser
);
    localparam int PXI_W = (SCREEN_BITS < PIX_W) ? SCREEN_BITS : PIX_W;
    localparam int PX_W  = PXI_W + SUBPIXEL_BITS;
    localparam int DP_W  = ((PX_W + 1 > CRD_W) ? PX_W + 1 : CRD_W) + 1;
    localparam int NUM_W = DP_W + 20;

    // whole pipeline advances unless a result is stuck at the output
    logic s_en;
    assign s_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = s_en;

    // chain links, index 0 is the setup output
    logic                  s_v   [QBITS+1];
    logic [NUM_W-1:0]      s_den [QBITS+1];
    logic [2:0][NUM_W-1:0] s_rem [QBITS+1];
    logic [2:0][QBITS-1:0] s_low [QBITS+1];
    logic [2:0][QBITS-1:0] s_quo [QBITS+1];
    t_side                 s_side[QBITS+1];

    tcdi_edge #(
        .SCREEN_BITS  (SCREEN_BITS),
        .SUBPIXEL_BITS(SUBPIXEL_BITS),
        .FRAC_W       (WEIGHT_FRAC_BITS),
        .NUM_W        (NUM_W)
    ) u_edge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_en),
        .i_valid(i_s_tvalid),
        .i_data (i_s_tdata),
        .o_valid(s_v[0]),
        .o_den  (s_den[0]),
        .o_rem  (s_rem[0]),
        .o_low  (s_low[0]),
        .o_side (s_side[0])
    );

    assign s_quo[0] = '0;

    // one division cell per quotient bit
    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        tcdi_div_cell #(
            .NUM_W(NUM_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (s_en),
            .i_valid(s_v[g]),
            .i_den  (s_den[g]),
            .i_rem  (s_rem[g]),
            .i_low  (s_low[g]),
            .i_quo  (s_quo[g]),
            .i_side (s_side[g]),
            .o_valid(s_v[g+1]),
            .o_den  (s_den[g+1]),
            .o_rem  (s_rem[g+1]),
            .o_low  (s_low[g+1]),
            .o_quo  (s_quo[g+1]),
            .o_side (s_side[g+1])
        );
    end

    tcdi_depth #(
        .FRAC_W(WEIGHT_FRAC_BITS)
    ) u_depth (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_en),
        .i_valid(s_v[QBITS]),
        .i_quo  (s_quo[QBITS]),
        .i_side (s_side[QBITS]),
        .o_valid(o_m_tvalid),
        .o_data (o_m_tdata),
        .o_user (o_m_tuser)
    );

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USER_DEGEN] |-> o_m_tdata == '0)
        else $error("degenerate result carries nonzero data");

    a_degen_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[USER_DEGEN] && o_m_tuser[USER_INSIDE]))
        else $error("degenerate triangle reported as covering");

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USER_INSIDE] |->
            !o_m_tdata[31] && !o_m_tdata[63] && !o_m_tdata[95])
        else $error("covered pixel has a negative weight");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
